/* src/phth_pkg.sv */
// Package for the packet head/tail history block.
// Shared sizes, register indexes and the packed history entry type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package phth_pkg;

  // History depth and the widths derived from it
  localparam int MAX_ROWS   = 16;
  localparam int ROW_IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);

  // Row and field widths
  localparam int MAX_LENGTH = 32;
  localparam int LEN_W      = 6;
  localparam int ROWS_W     = 5;
  localparam int BYTE_W     = 8;
  localparam int ROWNUM_W   = 6;

  // Configuration port
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // Register indexes (paddr[2])
  localparam logic REG_ROW_LENGTH   = 1'b0;
  localparam logic REG_HISTORY_ROWS = 1'b1;

  // Register reset values
  localparam logic [LEN_W-1:0]  ROW_LENGTH_RST   = LEN_W'(8);
  localparam logic [ROWS_W-1:0] HISTORY_ROWS_RST = ROWS_W'(16);

  typedef struct packed {
    logic [MAX_LENGTH-1:0] head;
    logic [MAX_LENGTH-1:0] tail;
  } hist_entry_t;

endpackage : phth_pkg

`default_nettype wire

/* src/phth_ifs.sv */
// Valid/ready channel interfaces for the packet head/tail history block.
// Depends on phth_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface phth_in_if;
  import phth_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] sample_byte;
  logic              end_of_packet;

  modport source (output valid, output sample_byte, output end_of_packet, input ready);
  modport sink   (input valid, input sample_byte, input end_of_packet, output ready);
endinterface : phth_in_if

interface phth_out_if;
  import phth_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MAX_LENGTH-1:0] head_row;
  logic [MAX_LENGTH-1:0] tail_row;
  logic [ROWNUM_W-1:0]   row_number;
  logic                  last_row;

  modport source (output valid, output head_row, output tail_row, output row_number,
                  output last_row, input ready);
  modport sink   (input valid, input head_row, input tail_row, input row_number,
                  input last_row, output ready);
endinterface : phth_out_if

`default_nettype wire

/* src/packet_head_tail_history.sv */
// Packet head/tail history: top level.
// Depends on phth_pkg and the channel interfaces in phth_ifs.sv.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat carries one packet byte, reduced to one bit (nonzero is 1).
// Bytes without an end mark are taken at one beat per cycle. The beat marked
// end_of_packet stores the packet's head row (first row_length bits, zero
// filled) and tail row (last row_length bits, MSB-aligned when the packet
// is short) into a circular history of up to history_rows entries, dropping
// the oldest entry when full, and then every stored row is sent out oldest
// first, row_number counting from 0 and last_row marking the newest row.
// The history lives in one single-port-read memory with a registered read, so
// each stored row is read out in turn, ST_READ sending the address and then
// ST_LOAD moving the data into the output register, waiting while the sink
// stalls; input is held off from the end-of-packet beat until the newest row
// sits in the output register.
// Writing either configuration register clears the history and drops the
// packet in progress. Registers: row_length at byte address 0 (0 acts as 1,
// above 32 acts as 32), history_rows at byte address 4 (0 acts as 1, above
// 16 acts as 16). No clearing pass runs after reset.
module packet_head_tail_history (
  input  wire                          clk,
  input  wire                          rst_n,
  phth_in_if.sink                      in_bus,
  phth_out_if.source                   out_bus,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [phth_pkg::APB_AW-1:0]  cfg_paddr,
  input  wire  [phth_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [phth_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import phth_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,   // taking bytes
    ST_READ,   // history address out to memory
    ST_LOAD    // read data back, move into output register
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [LEN_W-1:0]  row_length_r;
  logic [ROWS_W-1:0] history_rows_r;

  // Per-packet capture
  logic [MAX_LENGTH-1:0] head_r, tail_r;
  logic [LEN_W-1:0]      count_r;

  // History bookkeeping
  logic [ROW_CNT_W-1:0] held_r;
  logic [ROW_IDX_W-1:0] ptr_r;
  logic [ROW_CNT_W-1:0] n_r;    // rows in the current readout run
  logic [ROW_CNT_W-1:0] k_r;    // readout position

  // Output register
  logic                  out_valid_r;
  logic [MAX_LENGTH-1:0] out_head_r, out_tail_r;
  logic [ROWNUM_W-1:0]   out_rownum_r;
  logic                  out_last_r;

  // History memory
  hist_entry_t          mem [MAX_ROWS];
  hist_entry_t          rdata_r;
  logic                 wr_en, rd_en;
  logic [ROW_IDX_W-1:0] wr_addr, rd_addr;
  hist_entry_t          wr_data;

  // ---------------------------------------------------------------
  // Config port
  // ---------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[2])
      REG_ROW_LENGTH:   cfg_prdata = APB_DW'(row_length_r);
      REG_HISTORY_ROWS: cfg_prdata = APB_DW'(history_rows_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Effective settings
  // ---------------------------------------------------------------
  logic [LEN_W-1:0]      len_eff;
  logic [ROW_CNT_W-1:0]  rows_eff;
  logic [MAX_LENGTH-1:0] len_mask;

  always_comb begin
    if (row_length_r == '0)
      len_eff = LEN_W'(1);
    else if (int'(row_length_r) > MAX_LENGTH)
      len_eff = LEN_W'(MAX_LENGTH);
    else
      len_eff = row_length_r;

    if (history_rows_r == '0)
      rows_eff = ROW_CNT_W'(1);
    else if (int'(history_rows_r) > MAX_ROWS)
      rows_eff = ROW_CNT_W'(MAX_ROWS);
    else
      rows_eff = ROW_CNT_W'(history_rows_r);

    // len_eff is 1..32, so the shift is 0..31
    len_mask = {MAX_LENGTH{1'b1}} >> (LEN_W'(MAX_LENGTH) - len_eff);
  end

  // ---------------------------------------------------------------
  // Capture update for the beat in flight
  // ---------------------------------------------------------------
  logic                  in_fire, eop_fire, sample_bit;
  logic [MAX_LENGTH-1:0] head_upd, tail_upd, bit_word;
  logic [LEN_W-1:0]      count_upd;

  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_fire      = in_bus.valid & in_bus.ready;
  assign eop_fire     = in_fire & in_bus.end_of_packet;
  assign sample_bit   = |in_bus.sample_byte;
  assign bit_word     = MAX_LENGTH'(sample_bit);

  always_comb begin
    head_upd  = head_r;
    count_upd = count_r;
    if (count_r < len_eff) begin
      head_upd  = head_r | (bit_word << count_r);
      count_upd = count_r + LEN_W'(1);
    end
    tail_upd = ((tail_r >> 1) | (bit_word << (len_eff - LEN_W'(1)))) & len_mask;
  end

  // ---------------------------------------------------------------
  // Slot for the new row, new occupancy, readout address
  // ---------------------------------------------------------------
  logic [ROW_CNT_W:0]   slot_sum, slot_wrap, rd_sum, rd_wrap;
  logic                 full;
  logic [ROW_CNT_W-1:0] held_new;
  logic [ROW_IDX_W-1:0] ptr_new;

  always_comb begin
    full      = (held_r >= rows_eff);
    slot_sum  = (ROW_CNT_W+1)'(ptr_r) + (ROW_CNT_W+1)'(held_r);
    slot_wrap = (slot_sum >= (ROW_CNT_W+1)'(rows_eff))
              ? slot_sum - (ROW_CNT_W+1)'(rows_eff) : slot_sum;
    if (full) begin
      wr_addr  = ptr_r;
      held_new = rows_eff;
      ptr_new  = ((ROW_CNT_W+1)'(ptr_r) + 1'b1 >= (ROW_CNT_W+1)'(rows_eff))
               ? '0 : ptr_r + ROW_IDX_W'(1);
    end else begin
      wr_addr  = ROW_IDX_W'(slot_wrap);
      held_new = held_r + ROW_CNT_W'(1);
      ptr_new  = ptr_r;
    end

    rd_sum  = (ROW_CNT_W+1)'(ptr_r) + (ROW_CNT_W+1)'(k_r);
    rd_wrap = (rd_sum >= (ROW_CNT_W+1)'(rows_eff))
            ? rd_sum - (ROW_CNT_W+1)'(rows_eff) : rd_sum;
    rd_addr = ROW_IDX_W'(rd_wrap);
  end

  assign wr_en   = eop_fire & ~cfg_wr;
  assign wr_data = '{head: head_upd, tail: tail_upd};
  assign rd_en   = (state_r == ST_READ);

  // ---------------------------------------------------------------
  // History memory: one write, one registered read
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------
  // Control, capture and output register
  // ---------------------------------------------------------------
  logic out_free, is_last;
  assign out_free = ~out_valid_r | out_bus.ready;
  assign is_last  = ((ROW_CNT_W+1)'(k_r) + 1'b1) == (ROW_CNT_W+1)'(n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      row_length_r   <= ROW_LENGTH_RST;
      history_rows_r <= HISTORY_ROWS_RST;
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
      held_r         <= '0;
      ptr_r          <= '0;
      n_r            <= '0;
      k_r            <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // LOAD refills the output register itself when it is free
      if (out_valid_r && out_bus.ready && (state_r != ST_LOAD)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          // a register write wins over a beat taken in the same cycle
          if (in_fire && !cfg_wr) begin
            if (in_bus.end_of_packet) begin
              head_r  <= '0;
              tail_r  <= '0;
              count_r <= '0;
              held_r  <= held_new;
              ptr_r   <= ptr_new;
              n_r     <= held_new;
              k_r     <= '0;
              state_r <= ST_READ;
            end else begin
              head_r  <= head_upd;
              tail_r  <= tail_upd;
              count_r <= count_upd;
            end
          end
        end
        ST_READ: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_head_r   <= rdata_r.head;
            out_tail_r   <= rdata_r.tail;
            out_rownum_r <= ROWNUM_W'(k_r);
            out_last_r   <= is_last;
            if (is_last) begin
              state_r <= ST_IDLE;
            end else begin
              k_r     <= k_r + ROW_CNT_W'(1);
              state_r <= ST_READ;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // Any register write drops the packet in progress and the history
      if (cfg_wr) begin
        case (cfg_paddr[2])
          REG_ROW_LENGTH:   row_length_r   <= cfg_pwdata[LEN_W-1:0];
          REG_HISTORY_ROWS: history_rows_r <= cfg_pwdata[ROWS_W-1:0];
          default: ;
        endcase
        head_r  <= '0;
        tail_r  <= '0;
        count_r <= '0;
        held_r  <= '0;
        ptr_r   <= '0;
      end
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.head_row   = out_head_r;
  assign out_bus.tail_row   = out_tail_r;
  assign out_bus.row_number = out_rownum_r;
  assign out_bus.last_row   = out_last_r;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ROW_CNT_W+1)'(held_r) <= (ROW_CNT_W+1)'(rows_eff))
    else $error("history occupancy above configured depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ROW_CNT_W+1)'(ptr_r) < (ROW_CNT_W+1)'(rows_eff))
    else $error("oldest-row pointer outside configured depth");

  a_eop_starts_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (eop_fire && !cfg_wr) |=> (state_r == ST_READ && held_r != '0 && k_r == '0))
    else $error("packet end did not start a readout run");

  a_load_row_number: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && out_free) |=> (out_valid_r && out_rownum_r == ROWNUM_W'($past(k_r))))
    else $error("output row number does not match readout position");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && out_free && is_last) |=> (state_r == ST_IDLE && out_last_r))
    else $error("newest row did not close the readout run");
`endif

endmodule : packet_head_tail_history

`default_nettype wire
